FILE: hw/rtl/clipped_alpha_blend_fill_assert.svh
// assertion macros for the clipped alpha blend fill block
// expects clk and rst_n in the scope of the module that uses them
`ifndef CLIPPED_ALPHA_BLEND_FILL_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_FILL_ASSERT_SVH

// same-cycle implication
`define CABF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CABF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cabf_pkg.sv
// shared types and constants for the clipped alpha blend fill block
// used by the channel interfaces, the controller and the datapath
`timescale 1ns / 1ps

package cabf_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // operation codes
  localparam logic [1:0] OP_FILL   = 2'd0;
  localparam logic [1:0] OP_CANVAS = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RES      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 3'd5;

  // pixel modes
  localparam logic MODE_BGRA32 = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic row_go;
    logic addr_go;
    logic rd_cap;
    logic mul_go;
    logic wr_go;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic is_read;
    logic last_col;
    logic last_row;
  } status_t;

endpackage

FILE: hw/rtl/cabf_if.sv
// request, result and configuration channel interfaces
// depends on cabf_pkg for the configuration port widths
`timescale 1ns / 1ps

interface cabf_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [9:0] x_pos;
  logic signed [9:0] y_pos;
  logic [8:0]        square_size;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic [7:0]        alpha;

  modport source (output valid, operation, x_pos, y_pos, square_size, red, green, blue,
                  alpha, input ready);
  modport sink (input valid, operation, x_pos, y_pos, square_size, red, green, blue,
                alpha, output ready);
endinterface

interface cabf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [16:0] pixels_written;

  modport source (output valid, pixel_value, pixels_written, input ready);
  modport sink (input valid, pixel_value, pixels_written, output ready);
endinterface

interface cabf_cfg_if import cabf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hw/rtl/cabf_ctrl.sv
// controller state machine for the fill engine
// depends on cabf_pkg for the command and status structs
`timescale 1ns / 1ps
`include "clipped_alpha_blend_fill_assert.svh"

module cabf_ctrl import cabf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROW   = 8'b0000_0100,
    S_ADDR  = 8'b0000_1000,
    S_RDAT  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_WR    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state_r == S_CLEAR);
    cmd.accept   = in_valid && (state_r == S_IDLE);
    cmd.row_go   = (state_r == S_ROW) && !st.empty;
    cmd.addr_go  = (state_r == S_ADDR);
    cmd.rd_cap   = (state_r == S_RDAT);
    cmd.mul_go   = (state_r == S_MUL);
    cmd.wr_go    = (state_r == S_WR);
    cmd.load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_ROW;
      S_ROW:   state_nxt = st.empty ? S_DONE : S_ADDR;
      S_ADDR:  state_nxt = st.is_read ? S_RDAT : S_MUL;
      S_RDAT:  state_nxt = S_DONE;
      S_MUL:   state_nxt = S_WR;
      S_WR: begin
        if (st.last_col && st.last_row) state_nxt = S_DONE;
        else if (st.last_col) state_nxt = S_ROW;
        else state_nxt = S_ADDR;
      end
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CABF_ASSERT_NXT(a_accept_to_row, cmd.accept, state_r == S_ROW, "accepted request did not start a row")
  `CABF_ASSERT_NXT(a_last_pixel_done, cmd.wr_go && st.last_col && st.last_row, state_r == S_DONE, "walk did not end after last pixel")
  `CABF_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_r || out_ready, "result overwritten while pending")

endmodule

FILE: hw/rtl/cabf_dp.sv
// datapath: configuration registers, clipping, address, blend and pixel store
// depends on cabf_pkg for codes and the command and status structs
`timescale 1ns / 1ps
`include "clipped_alpha_blend_fill_assert.svh"

module cabf_dp import cabf_pkg::*; #(
  parameter int MAX_RES     = 256,
  parameter int STORE_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            operation,
  input  logic signed [9:0]     x_pos,
  input  logic signed [9:0]     y_pos,
  input  logic [8:0]            square_size,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            alpha,
  output logic [31:0]           pixel_value,
  output logic [16:0]           pixels_written
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LIN_W  = 20;

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // configuration
  logic       mode_r;
  logic [8:0] xres_r, yres_r, pitch_r;
  logic [7:0] xoff_r, yoff_r;
  logic [8:0] xr, yr;

  // item and walk
  logic              read_r, empty_r;
  logic [7:0]        red_r, green_r, blue_r, alpha_r;
  logic [8:0]        x0_r, x1_r, y1_r, col_r, row_r;
  logic [18:0]       row_base_r;
  logic [ADDR_W-1:0] addr_r;
  logic              ok_r;
  logic [31:0]       rd_r, value_r, pix_val_r;
  logic [16:0]       count_r, pix_cnt_r;
  logic [15:0]       pc_b_r, pc_g_r, pc_r_r, pd_b_r, pd_g_r, pd_r_r, pd_a_r;
  logic [ADDR_W-1:0] clr_r;

  logic [31:0] mem [STORE_DEPTH];

  // clipping of the accepted request
  logic signed [11:0] sx, sy, sz, lo_x, lo_y, hi_x, hi_y, cx0, cy0, cx1, cy1, sxr, syr;
  logic [LIN_W-1:0]   lin;
  logic               lin_ok;
  logic [31:0]        new_px;
  logic [7:0]         na, inv_a;

  assign xr  = (32'(xres_r) > 32'(MAX_RES)) ? 9'(MAX_RES) : xres_r;
  assign yr  = (32'(yres_r) > 32'(MAX_RES)) ? 9'(MAX_RES) : yres_r;
  assign sxr = $signed({3'b0, xr});
  assign syr = $signed({3'b0, yr});
  assign sx  = 12'(x_pos);
  assign sy  = 12'(y_pos);
  assign sz  = $signed({3'b0, square_size});

  always_comb begin
    case (operation)
      OP_FILL: begin
        lo_x = sx;
        lo_y = sy;
        hi_x = sx + sz;
        hi_y = sy + sz;
      end
      OP_CANVAS: begin
        lo_x = '0;
        lo_y = '0;
        hi_x = sxr;
        hi_y = syr;
      end
      OP_READ: begin
        lo_x = sx;
        lo_y = sy;
        hi_x = sx + 12'sd1;
        hi_y = sy + 12'sd1;
      end
      default: begin
        lo_x = '0;
        lo_y = '0;
        hi_x = '0;
        hi_y = '0;
      end
    endcase
    cx0 = (lo_x < 12'sd0) ? 12'sd0 : lo_x;
    cy0 = (lo_y < 12'sd0) ? 12'sd0 : lo_y;
    cx1 = (hi_x > sxr) ? sxr : hi_x;
    cy1 = (hi_y > syr) ? syr : hi_y;
  end

  assign lin    = LIN_W'(row_base_r) + LIN_W'(col_r) + LIN_W'(xoff_r);
  assign lin_ok = 32'(lin) < 32'(STORE_DEPTH);

  assign inv_a = 8'd255 - alpha_r;
  assign na    = alpha_r + div255(pd_a_r);

  always_comb begin
    if (mode_r == MODE_RGB565) begin
      new_px = {16'b0, red_r[7:3], green_r[7:2], blue_r[7:3]};
    end else begin
      new_px = {na,
                div255(pc_r_r) + div255(pd_r_r),
                div255(pc_g_r) + div255(pd_g_r),
                div255(pc_b_r) + div255(pd_b_r)};
    end
  end

  assign st.clr_last = (clr_r == ADDR_W'(STORE_DEPTH - 1));
  assign st.empty    = empty_r;
  assign st.is_read  = read_r;
  assign st.last_col = ({1'b0, col_r} + 10'd1) == {1'b0, x1_r};
  assign st.last_row = ({1'b0, row_r} + 10'd1) == {1'b0, y1_r};

  assign pixel_value    = pix_val_r;
  assign pixels_written = pix_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BGRA32;
      xres_r  <= 9'd256;
      yres_r  <= 9'd256;
      xoff_r  <= '0;
      yoff_r  <= '0;
      pitch_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PIXEL_MODE: mode_r  <= cfg_data[0];
        CFG_X_RES:      xres_r  <= cfg_data;
        CFG_Y_RES:      yres_r  <= cfg_data;
        CFG_X_OFFSET:   xoff_r  <= cfg_data[7:0];
        CFG_Y_OFFSET:   yoff_r  <= cfg_data[7:0];
        CFG_LINE_PITCH: pitch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_wr) clr_r <= clr_r + 1'b1;
  end

  // pixels stored by the current request
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.accept) count_r <= '0;
    else if (cmd.wr_go) count_r <= count_r + 17'(ok_r);
  end

  // walk and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_r  <= (operation == OP_READ);
      empty_r <= !(cx0 < cx1) || !(cy0 < cy1);
      x0_r    <= cx0[8:0];
      x1_r    <= cx1[8:0];
      y1_r    <= cy1[8:0];
      col_r   <= cx0[8:0];
      row_r   <= cy0[8:0];
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      alpha_r <= alpha;
      value_r <= '0;
    end
    if (cmd.row_go) begin
      row_base_r <= ({1'b0, row_r} + {2'b0, yoff_r}) * pitch_r;
    end
    if (cmd.addr_go) begin
      addr_r <= ADDR_W'(lin);
      ok_r   <= lin_ok;
    end
    if (cmd.rd_cap) begin
      value_r <= ok_r ? rd_r : 32'd0;
    end
    if (cmd.mul_go) begin
      pc_b_r <= blue_r * alpha_r;
      pc_g_r <= green_r * alpha_r;
      pc_r_r <= red_r * alpha_r;
      pd_b_r <= rd_r[7:0] * inv_a;
      pd_g_r <= rd_r[15:8] * inv_a;
      pd_r_r <= rd_r[23:16] * inv_a;
      pd_a_r <= rd_r[31:24] * inv_a;
    end
    if (cmd.wr_go) begin
      if (st.last_col) begin
        col_r <= x0_r;
        row_r <= row_r + 9'd1;
      end else begin
        col_r <= col_r + 9'd1;
      end
    end
    if (cmd.load_out) begin
      pix_val_r <= value_r;
      pix_cnt_r <= count_r;
    end
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) mem[clr_r] <= '0;
    else if (cmd.wr_go && ok_r) mem[addr_r] <= new_px;
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_go) rd_r <= mem[ADDR_W'(lin)];
  end

  `CABF_ASSERT_NXT(a_count_hold, !cmd.accept && !cmd.wr_go, $stable(count_r), "pixel count changed without a write")
  `CABF_ASSERT_IMP(a_write_in_store, cmd.wr_go && ok_r, 32'(addr_r) < 32'(STORE_DEPTH), "pixel write beyond store")

endmodule

FILE: hw/rtl/clipped_alpha_blend_fill.sv
// clipped alpha blend fill: a 32-bit pixel store with a square and canvas fill engine
// channels: in_req (request), out_res (one result per request), cfg_req (register write)
// register writes are taken in every cycle and must only arrive while the block is idle
// after reset the store is swept to zero, one entry per cycle, all STORE_DEPTH entries;
// no request is taken during the sweep
// a request is taken only while the engine is idle; one request is worked at a time
// read: the row, address and read-capture steps, then the result register is loaded
// fill of a clipped w x h area: a row step for each row, then the read,
// multiply and write-back steps through the store for each pixel of the row
// an empty area (clipped away, zero size, unused code) goes from the row step straight to the done step
// the result sits in an output register; the next request is taken while it waits
// if the receiver stalls with a result still pending, a finished request waits
// before the result register until it frees up
`timescale 1ns / 1ps

module clipped_alpha_blend_fill import cabf_pkg::*; #(
  parameter int MAX_RES     = 256,
  parameter int STORE_DEPTH = 65536
) (
  input logic        clk,
  input logic        rst_n,
  cabf_in_if.sink    in_req,
  cabf_out_if.source out_res,
  cabf_cfg_if.sink   cfg_req
);

  cmd_t    cmd;
  status_t st;

  assign cfg_req.ready = 1'b1;

  cabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  cabf_dp #(
    .MAX_RES     (MAX_RES),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_req.valid),
    .cfg_idx        (cfg_req.reg_index),
    .cfg_data       (cfg_req.wr_data),
    .operation      (in_req.operation),
    .x_pos          (in_req.x_pos),
    .y_pos          (in_req.y_pos),
    .square_size    (in_req.square_size),
    .red            (in_req.red),
    .green          (in_req.green),
    .blue           (in_req.blue),
    .alpha          (in_req.alpha),
    .pixel_value    (out_res.pixel_value),
    .pixels_written (out_res.pixels_written)
  );

endmodule
